// ===== hdl/ppls_pkg.sv =====
package ppls_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [20:0] SPEC_CAP = 21'h100000;
    localparam logic [15:0] OUT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X     = 3'd0,
        CFG_LIGHT_Y     = 3'd1,
        CFG_LIGHT_Z     = 3'd2,
        CFG_LIGHT_RED   = 3'd3,
        CFG_LIGHT_GREEN = 3'd4,
        CFG_LIGHT_BLUE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] eye_x;
        logic signed [15:0] eye_y;
        logic signed [15:0] eye_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               shadowed;
        logic        [47:0] surface_color;
        logic        [63:0] material_coeffs;
    } t_in;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } t_out;

    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                   input int unsigned amt);
        logic signed [63:0] half;
        logic signed [63:0] mv;
        half = 64'sd1 <<< (amt - 1);
        mv = -v;
        if (v >= 0) begin
            return (v + half) >>> amt;
        end
        return -((mv + half) >>> amt);
    endfunction

    function automatic logic [15:0] log_frac(input logic [16:0] y);
        logic [63:0] m;
        logic [15:0] r;
        m = {33'b0, y, 14'b0};
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] exp_inv(input logic [15:0] f);
        logic [17:0] lo;
        logic [17:0] hi;
        logic [17:0] mid;
        lo = 18'd65536;
        hi = 18'd131071;
        for (int it = 0; it < 18; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 18'd1) >> 1;
                if (log_frac(mid[16:0]) <= f) begin
                    lo = mid;
                end else begin
                    hi = mid - 18'd1;
                end
            end
        end
        return lo[16:0];
    endfunction

endpackage

// ===== hdl/phong_point_light_shader.sv =====
// Pipeline: each input transaction moves through the stage registers in order to the output register.
// Throughput: one transaction per cycle; all stages advance together whenever
// the output register is empty or being taken, so a stall holds every stage.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// light registers with position zero and unit intensity.
module phong_point_light_shader #(
    parameter int POW_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ppls_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ppls_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDXW = (POW_TABLE_DEPTH > 1) ? $clog2(POW_TABLE_DEPTH) : 1;
    localparam int DW = $clog2(POW_TABLE_DEPTH + 1);

    localparam int S_IN   = 0;
    localparam int S_SQC  = 1;
    localparam int S_SUM  = 2;
    localparam int S_SQRT = 3;
    localparam int S_NUM  = 28;
    localparam int S_DIV  = 29;
    localparam int S_LV   = 44;
    localparam int S_PR   = 45;
    localparam int S_LDN  = 46;
    localparam int S_LNN  = 47;
    localparam int S_RV   = 48;
    localparam int S_PE   = 49;
    localparam int S_RDE  = 50;
    localparam int S_NORM = 51;
    localparam int S_IDX  = 52;
    localparam int S_LOG  = 53;
    localparam int S_LGSH = 54;
    localparam int S_T    = 55;
    localparam int S_EIDX = 56;
    localparam int S_EXP  = 57;
    localparam int S_MUL1 = 58;
    localparam int S_MUL2 = 59;
    localparam int S_TERM = 60;
    localparam int S_OUT  = 61;
    localparam int NSTG   = 62;

    typedef struct packed {
        logic [2:0][15:0] ev;
        logic [2:0][15:0] nv;
        logic             shadow;
        logic [2:0][15:0] col;
        logic [63:0]      mat;
        logic [2:0][24:0] d;
        logic [2:0][24:0] mag;
        logic [2:0]       neg;
        logic [2:0][48:0] sqc;
        logic [49:0]      rem;
        logic [24:0]      root;
        logic [2:0][38:0] num;
        logic [2:0][14:0] q;
        logic [2:0][15:0] lv;
        logic [2:0][31:0] pr;
        logic [17:0]      ldn;
        logic [2:0][33:0] lnn;
        logic [2:0][20:0] rv;
        logic [2:0][36:0] pe;
        logic [23:0]      rde;
        logic             dif_on;
        logic             spec_on;
        logic [4:0]       p;
        logic [21:0]      frac;
        logic [IDXW-1:0]  idx;
        logic [15:0]      logv;
        logic [37:0]      prod;
        logic [17:0]      k;
        logic [15:0]      f;
        logic [IDXW-1:0]  eidx;
        logic [16:0]      e;
        logic [2:0][31:0] iks;
        logic [2:0][19:0] eff;
        logic [2:0][48:0] v;
        logic [2:0][23:0] amb;
        logic [2:0][35:0] ek;
        logic [2:0][20:0] spec;
        logic [2:0][26:0] dif;
        logic [2:0][15:0] outv;
    } t_item;

    t_item            r_st [NSTG];
    t_item            n_st [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic             w_adv;

    logic [23:0]      r_light_pos [3];
    logic [15:0]      r_light_int [3];

    logic [15:0]      w_log_tab [POW_TABLE_DEPTH];
    logic [16:0]      w_exp_tab [POW_TABLE_DEPTH];

    for (genvar g = 0; g < POW_TABLE_DEPTH; g++) begin : g_tab
        localparam int FR = (g * 65536) / POW_TABLE_DEPTH;
        assign w_log_tab[g] = ppls_pkg::log_frac(17'(65536 + FR));
        assign w_exp_tab[g] = ppls_pkg::exp_inv(16'(FR));
    end

    assign w_adv       = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_out_data.out_red   = r_st[S_OUT].outv[0];
        o_out_data.out_green = r_st[S_OUT].outv[1];
        o_out_data.out_blue  = r_st[S_OUT].outv[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_light_pos[c] <= '0;
                r_light_int[c] <= 16'd4096;
            end
        end else if (i_cfg_valid) begin
            unique case (ppls_pkg::t_cfg_idx'(i_cfg_index))
                ppls_pkg::CFG_LIGHT_X:     r_light_pos[0] <= i_cfg_data;
                ppls_pkg::CFG_LIGHT_Y:     r_light_pos[1] <= i_cfg_data;
                ppls_pkg::CFG_LIGHT_Z:     r_light_pos[2] <= i_cfg_data;
                ppls_pkg::CFG_LIGHT_RED:   r_light_int[0] <= i_cfg_data[15:0];
                ppls_pkg::CFG_LIGHT_GREEN: r_light_int[1] <= i_cfg_data[15:0];
                ppls_pkg::CFG_LIGHT_BLUE:  r_light_int[2] <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [23:0]        pos [3];
        logic signed [24:0] ds;
        logic signed [49:0] sq_t;
        logic [49:0]        ssum;
        logic [51:0]        tmp;
        logic [39:0]        dv;
        logic [15:0]        qv;
        logic signed [31:0] pr_t;
        logic signed [33:0] s34;
        logic signed [63:0] t64;
        logic signed [33:0] lnn_t;
        logic signed [36:0] pe_t;
        logic signed [38:0] s39;
        logic [22:0]        x;
        logic [22:0]        m;
        logic [4:0]         pp;
        logic [21+DW:0]     pri;
        logic [15+DW:0]     pre;
        logic [4:0]         pm14;
        logic signed [20:0] lg;
        logic signed [37:0] prod_t;
        logic [33:0]        t34;
        logic [32:0]        ce;
        logic [36:0]        am;
        logic [53:0]        dm;
        logic signed [17:0] kk;
        logic signed [18:0] rs;
        logic [49:0]        rr;
        logic [69:0]        ll;
        logic [20:0]        sp;
        logic [27:0]        tot;

        pos[0] = i_in_data.pos_x;
        pos[1] = i_in_data.pos_y;
        pos[2] = i_in_data.pos_z;

        n_st[S_IN] = r_st[S_IN];
        for (int s = 1; s < NSTG; s++) begin
            n_st[s] = r_st[s-1];
        end

        n_st[S_IN].ev[0]  = i_in_data.eye_x;
        n_st[S_IN].ev[1]  = i_in_data.eye_y;
        n_st[S_IN].ev[2]  = i_in_data.eye_z;
        n_st[S_IN].nv[0]  = i_in_data.norm_x;
        n_st[S_IN].nv[1]  = i_in_data.norm_y;
        n_st[S_IN].nv[2]  = i_in_data.norm_z;
        n_st[S_IN].shadow = i_in_data.shadowed;
        n_st[S_IN].col[0] = i_in_data.surface_color[47:32];
        n_st[S_IN].col[1] = i_in_data.surface_color[31:16];
        n_st[S_IN].col[2] = i_in_data.surface_color[15:0];
        n_st[S_IN].mat    = i_in_data.material_coeffs;
        for (int c = 0; c < 3; c++) begin
            n_st[S_IN].d[c] = {r_light_pos[c][23], r_light_pos[c]} - {pos[c][23], pos[c]};
        end

        for (int c = 0; c < 3; c++) begin
            ds = $signed(r_st[S_SQC-1].d[c]);
            sq_t = ds * ds;
            n_st[S_SQC].sqc[c] = sq_t[48:0];
            n_st[S_SQC].mag[c] = ds[24] ? 25'(-ds) : 25'(ds);
            n_st[S_SQC].neg[c] = ds[24];
        end

        ssum = {1'b0, r_st[S_SUM-1].sqc[0]} + {1'b0, r_st[S_SUM-1].sqc[1]}
             + {1'b0, r_st[S_SUM-1].sqc[2]};
        n_st[S_SUM].rem  = ssum;
        n_st[S_SUM].root = '0;

        for (int b = 0; b < 25; b++) begin
            tmp = ({27'b0, r_st[S_SQRT+b-1].root} << (25 - b))
                + (52'd1 << (2 * (24 - b)));
            if ({2'b0, r_st[S_SQRT+b-1].rem} >= tmp) begin
                t64 = 64'({2'b0, r_st[S_SQRT+b-1].rem} - tmp);
                n_st[S_SQRT+b].rem  = t64[49:0];
                n_st[S_SQRT+b].root = r_st[S_SQRT+b-1].root | (25'd1 << (24 - b));
            end
        end

        for (int c = 0; c < 3; c++) begin
            n_st[S_NUM].num[c] = {r_st[S_NUM-1].mag[c], 14'b0}
                               + {14'b0, r_st[S_NUM-1].root >> 1};
            n_st[S_NUM].q[c] = '0;
        end

        for (int i = 0; i < 15; i++) begin
            for (int c = 0; c < 3; c++) begin
                dv = {15'b0, r_st[S_DIV+i-1].root} << (14 - i);
                if ({1'b0, r_st[S_DIV+i-1].num[c]} >= dv) begin
                    t64 = 64'({1'b0, r_st[S_DIV+i-1].num[c]} - dv);
                    n_st[S_DIV+i].num[c] = t64[38:0];
                    n_st[S_DIV+i].q[c][14-i] = 1'b1;
                end
            end
        end

        for (int c = 0; c < 3; c++) begin
            qv = {1'b0, r_st[S_LV-1].q[c]};
            if (r_st[S_LV-1].root == '0) begin
                n_st[S_LV].lv[c] = '0;
            end else if (r_st[S_LV-1].neg[c]) begin
                n_st[S_LV].lv[c] = -qv;
            end else begin
                n_st[S_LV].lv[c] = qv;
            end
        end

        for (int c = 0; c < 3; c++) begin
            pr_t = $signed(r_st[S_PR-1].lv[c]) * $signed(r_st[S_PR-1].nv[c]);
            n_st[S_PR].pr[c] = pr_t;
        end

        s34 = 34'($signed(r_st[S_LDN-1].pr[0])) + 34'($signed(r_st[S_LDN-1].pr[1]))
            + 34'($signed(r_st[S_LDN-1].pr[2]));
        t64 = ppls_pkg::rnd_sh(64'(s34), 14);
        n_st[S_LDN].ldn = t64[17:0];

        for (int c = 0; c < 3; c++) begin
            lnn_t = $signed(r_st[S_LNN-1].ldn) * $signed(r_st[S_LNN-1].nv[c]);
            n_st[S_LNN].lnn[c] = lnn_t;
        end

        for (int c = 0; c < 3; c++) begin
            t64 = ppls_pkg::rnd_sh(64'($signed(r_st[S_RV-1].lnn[c])), 13)
                - 64'($signed(r_st[S_RV-1].lv[c]));
            n_st[S_RV].rv[c] = t64[20:0];
        end

        for (int c = 0; c < 3; c++) begin
            pe_t = $signed(r_st[S_PE-1].rv[c]) * $signed(r_st[S_PE-1].ev[c]);
            n_st[S_PE].pe[c] = pe_t;
        end

        s39 = 39'($signed(r_st[S_RDE-1].pe[0])) + 39'($signed(r_st[S_RDE-1].pe[1]))
            + 39'($signed(r_st[S_RDE-1].pe[2]));
        t64 = ppls_pkg::rnd_sh(64'(s39), 14);
        n_st[S_RDE].rde     = t64[23:0];
        n_st[S_RDE].dif_on  = !r_st[S_RDE-1].shadow && ($signed(r_st[S_RDE-1].ldn) > 0);
        n_st[S_RDE].spec_on = !r_st[S_RDE-1].shadow && ($signed(r_st[S_RDE-1].ldn) > 0)
                            && ($signed(t64[23:0]) > 0);

        x = r_st[S_NORM-1].rde[22:0];
        pp = '0;
        for (int i = 0; i < 23; i++) begin
            if (x[i]) begin
                pp = 5'(i);
            end
        end
        m = x << (5'd22 - pp);
        n_st[S_NORM].p    = pp;
        n_st[S_NORM].frac = m[21:0];

        pri = {{DW{1'b0}}, r_st[S_IDX-1].frac} * {22'b0, DW'(POW_TABLE_DEPTH)};
        n_st[S_IDX].idx = pri[21+IDXW:22];

        n_st[S_LOG].logv = w_log_tab[r_st[S_LOG-1].idx];

        pm14 = r_st[S_LGSH-1].p - 5'd14;
        lg = $signed({pm14, r_st[S_LGSH-1].logv});
        prod_t = lg * $signed({1'b0, r_st[S_LGSH-1].mat[15:0]});
        n_st[S_LGSH].prod = prod_t;

        t64 = ppls_pkg::rnd_sh(64'($signed(r_st[S_T-1].prod)), 4);
        t34 = t64[33:0];
        n_st[S_T].k = t34[33:16];
        n_st[S_T].f = t34[15:0];

        pre = {{DW{1'b0}}, r_st[S_EIDX-1].f} * {16'b0, DW'(POW_TABLE_DEPTH)};
        n_st[S_EIDX].eidx = pre[15+IDXW:16];

        n_st[S_EXP].e = w_exp_tab[r_st[S_EXP-1].eidx];

        for (int c = 0; c < 3; c++) begin
            n_st[S_MUL1].iks[c] = r_light_int[c] * r_st[S_MUL1-1].mat[31:16];
            ce = {17'b0, r_st[S_MUL1-1].col[c]} * {17'b0, r_light_int[c]} + 33'd2048;
            n_st[S_MUL1].eff[c] = ce[31:12];
        end

        for (int c = 0; c < 3; c++) begin
            n_st[S_MUL2].v[c] = {17'b0, r_st[S_MUL2-1].iks[c]} * {32'b0, r_st[S_MUL2-1].e};
            am = {17'b0, r_st[S_MUL2-1].eff[c]} * {21'b0, r_st[S_MUL2-1].mat[63:48]}
               + 37'd2048;
            n_st[S_MUL2].amb[c] = am[35:12];
            n_st[S_MUL2].ek[c] = {16'b0, r_st[S_MUL2-1].eff[c]}
                               * {20'b0, r_st[S_MUL2-1].mat[47:32]};
        end

        kk = $signed(r_st[S_TERM-1].k);
        for (int c = 0; c < 3; c++) begin
            dm = {18'b0, r_st[S_TERM-1].ek[c]} * {37'b0, r_st[S_TERM-1].ldn[16:0]}
               + (54'd1 << 25);
            n_st[S_TERM].dif[c] = r_st[S_TERM-1].dif_on ? dm[52:26] : '0;
            sp = '0;
            rr = '0;
            ll = '0;
            if (kk < 18'sd28) begin
                rs = 19'sd28 - {kk[17], kk};
                if (rs < 19'sd50) begin
                    rr = ({1'b0, r_st[S_TERM-1].v[c]} + (50'd1 << (rs[5:0] - 6'd1)))
                       >> rs[5:0];
                    sp = (rr > {29'b0, ppls_pkg::SPEC_CAP}) ? ppls_pkg::SPEC_CAP : rr[20:0];
                end
            end else begin
                rs = {kk[17], kk} - 19'sd28;
                if (r_st[S_TERM-1].v[c] == '0) begin
                    sp = '0;
                end else if (rs >= 19'sd21) begin
                    sp = ppls_pkg::SPEC_CAP;
                end else begin
                    ll = {21'b0, r_st[S_TERM-1].v[c]} << rs[4:0];
                    sp = (ll > {49'b0, ppls_pkg::SPEC_CAP}) ? ppls_pkg::SPEC_CAP : ll[20:0];
                end
            end
            n_st[S_TERM].spec[c] = r_st[S_TERM-1].spec_on ? sp : '0;
        end

        for (int c = 0; c < 3; c++) begin
            tot = {4'b0, r_st[S_OUT-1].amb[c]} + {1'b0, r_st[S_OUT-1].dif[c]}
                + {7'b0, r_st[S_OUT-1].spec[c]};
            n_st[S_OUT].outv[c] = (tot > {12'b0, ppls_pkg::OUT_MAX}) ?
                                  ppls_pkg::OUT_MAX : tot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NSTG; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    a_advance_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_vld[1] == $past(r_vld[0])))
        else $error("stage valid did not advance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("stage valid moved during stall");

    a_spec_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_TERM] && r_st[S_TERM].spec_on) |-> r_st[S_TERM].dif_on)
        else $error("specular enabled without diffuse");

    a_spec_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_TERM] |-> (r_st[S_TERM].spec[0] <= ppls_pkg::SPEC_CAP
                           && r_st[S_TERM].spec[1] <= ppls_pkg::SPEC_CAP
                           && r_st[S_TERM].spec[2] <= ppls_pkg::SPEC_CAP))
        else $error("specular term above cap");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_LV] && r_st[S_LV].root == '0) |-> (r_st[S_LV].lv == '0))
        else $error("light vector not zero for zero distance");

endmodule

// ===== bench/phong_point_light_shader_tb.sv =====
`timescale 1ns / 1ps

module phong_point_light_shader_tb;

    localparam int TABLE_DEPTH = 256;
    localparam logic [63:0] TERM_LIMIT = 64'd1 << 20;
    localparam logic [ppls_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [ppls_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ppls_pkg::t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ppls_pkg::t_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ppls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ppls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [23:0] light_pos [3];
    logic [15:0] light_level [3];
    logic [15:0] log_lut [TABLE_DEPTH];
    logic [16:0] exp_lut [TABLE_DEPTH];
    ppls_pkg::t_out shade_queue [$];
    int err_count = 0;
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;

    phong_point_light_shader i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -(((-v) + half) >>> s);
    endfunction

    function automatic logic [15:0] log2_fraction(logic [16:0] y);
        logic [63:0] m;
        logic [15:0] r;
        m = {47'b0, y} << 14;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    task automatic build_pow_tables();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        logic [15:0] f;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            f = 16'((64'(i) << 16) / TABLE_DEPTH);
            log_lut[i] = log2_fraction(17'(65536 + f));
            lo = 65536;
            hi = 131071;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (log2_fraction(mid[16:0]) <= f) lo = mid;
                else hi = mid - 1;
            end
            exp_lut[i] = lo[16:0];
        end
    endtask

    function automatic ppls_pkg::t_out shade_point(ppls_pkg::t_in it);
        longint d [3];
        longint lv [3];
        longint nv [3];
        longint ev [3];
        longint rv [3];
        longint ldn, rde, lg, t, k, r;
        logic [63:0] sq, len, mag, x, idx, f, e, v, spec, eff, tot;
        logic [63:0] col [3];
        logic [63:0] ka, kd, ks, sh;
        logic [15:0] och [3];
        int p;
        ppls_pkg::t_out res;
        d[0] = longint'(light_pos[0]) - longint'(it.pos_x);
        d[1] = longint'(light_pos[1]) - longint'(it.pos_y);
        d[2] = longint'(light_pos[2]) - longint'(it.pos_z);
        ev[0] = it.eye_x;
        ev[1] = it.eye_y;
        ev[2] = it.eye_z;
        nv[0] = it.norm_x;
        nv[1] = it.norm_y;
        nv[2] = it.norm_z;
        col[0] = it.surface_color[47:32];
        col[1] = it.surface_color[31:16];
        col[2] = it.surface_color[15:0];
        ka = it.material_coeffs[63:48];
        kd = it.material_coeffs[47:32];
        ks = it.material_coeffs[31:16];
        sh = it.material_coeffs[15:0];
        sq = 64'(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
        len = int_sqrt(sq);
        for (int c = 0; c < 3; c++) begin
            if (len == 0) begin
                lv[c] = 0;
            end else begin
                mag = 64'(d[c] < 0 ? -d[c] : d[c]);
                lv[c] = longint'(((mag << 14) + len / 2) / len);
                if (d[c] < 0) lv[c] = -lv[c];
            end
        end
        ldn = round_shift(lv[0] * nv[0] + lv[1] * nv[1] + lv[2] * nv[2], 14);
        rde = 0;
        k = 0;
        e = 0;
        if (!it.shadowed && ldn > 0) begin
            for (int c = 0; c < 3; c++) rv[c] = -lv[c] + round_shift(ldn * nv[c], 13);
            rde = round_shift(rv[0] * ev[0] + rv[1] * ev[1] + rv[2] * ev[2], 14);
            if (rde > 0) begin
                x = 64'(rde);
                p = 0;
                while (p < 63 && (x >> (p + 1)) != 0) p++;
                idx = ((x - (64'd1 << p)) * TABLE_DEPTH) >> p;
                lg = (longint'(p) - 14) * 65536 + longint'(log_lut[idx]);
                t = round_shift(lg * longint'(sh), 4);
                if (t >= 0) k = t >>> 16;
                else k = -(((-t) + 65535) >>> 16);
                f = 64'(t - k * 65536);
                e = exp_lut[(f * TABLE_DEPTH) >> 16];
            end
        end
        for (int c = 0; c < 3; c++) begin
            eff = (col[c] * 64'(light_level[c]) + 64'd2048) >> 12;
            tot = (eff * ka + 64'd2048) >> 12;
            if (!it.shadowed && ldn > 0) begin
                tot = tot + ((eff * kd * 64'(ldn) + (64'd1 << 25)) >> 26);
                if (rde > 0) begin
                    v = 64'(light_level[c]) * ks * e;
                    r = 28 - k;
                    if (r > 0) begin
                        if (r >= 60) spec = 0;
                        else spec = (v + (64'd1 << (r - 1))) >> r;
                    end else if (v == 0) begin
                        spec = 0;
                    end else if (-r >= 40 || v > (TERM_LIMIT >> (-r))) begin
                        spec = TERM_LIMIT;
                    end else begin
                        spec = v << (-r);
                    end
                    if (spec > TERM_LIMIT) spec = TERM_LIMIT;
                    tot = tot + spec;
                end
            end
            och[c] = (tot > 64'(ppls_pkg::OUT_MAX)) ? ppls_pkg::OUT_MAX : tot[15:0];
        end
        res.out_red = och[0];
        res.out_green = och[1];
        res.out_blue = och[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        ppls_pkg::t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (shade_queue.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result %h", out_data);
            end else begin
                want = shade_queue.pop_front();
                if (out_data.out_red !== want.out_red
                        || out_data.out_green !== want.out_green
                        || out_data.out_blue !== want.out_blue) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected r=%h g=%h b=%h, actual r=%h g=%h b=%h",
                                 want.out_red, want.out_green, want.out_blue,
                                 out_data.out_red, out_data.out_green, out_data.out_blue);
                    end
                end
            end
        end
    end

    task automatic send_point(ppls_pkg::t_in it);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        shade_queue.push_back(shade_point(it));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [ppls_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppls_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            ppls_pkg::CFG_LIGHT_X:     light_pos[0] = val;
            ppls_pkg::CFG_LIGHT_Y:     light_pos[1] = val;
            ppls_pkg::CFG_LIGHT_Z:     light_pos[2] = val;
            ppls_pkg::CFG_LIGHT_RED:   light_level[0] = val[15:0];
            ppls_pkg::CFG_LIGHT_GREEN: light_level[1] = val[15:0];
            ppls_pkg::CFG_LIGHT_BLUE:  light_level[2] = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (shade_queue.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_light(logic [23:0] lx, logic [23:0] ly, logic [23:0] lz,
                             logic [23:0] lr, logic [23:0] lgr, logic [23:0] lb);
        drain();
        write_reg(ppls_pkg::CFG_LIGHT_X, lx);
        write_reg(ppls_pkg::CFG_LIGHT_Y, ly);
        write_reg(ppls_pkg::CFG_LIGHT_Z, lz);
        write_reg(ppls_pkg::CFG_LIGHT_RED, lr);
        write_reg(ppls_pkg::CFG_LIGHT_GREEN, lgr);
        write_reg(ppls_pkg::CFG_LIGHT_BLUE, lb);
    endtask

    function automatic ppls_pkg::t_in plain_point();
        ppls_pkg::t_in it;
        it = '0;
        it.eye_z = 16'sd16384;
        it.norm_z = 16'sd16384;
        it.surface_color = {16'd4096, 16'd4096, 16'd4096};
        it.material_coeffs = {16'h0400, 16'h0800, 16'h0800, 16'h0100};
        return it;
    endfunction

    function automatic logic signed [15:0] to_q14(real v);
        return 16'($rtoi(v * 16384.0));
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    endfunction

    function automatic ppls_pkg::t_in random_point();
        ppls_pkg::t_in it;
        real l [3];
        real n [3];
        real ev [3];
        real mag, dot;
        int off;
        it.shadowed = ($urandom_range(0, 99) < 20);
        it.surface_color = 48'({$urandom, $urandom});
        it.material_coeffs = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 15) begin
            {it.pos_x, it.pos_y, it.pos_z} = 72'({$urandom, $urandom, $urandom});
            {it.eye_x, it.eye_y, it.eye_z} = 48'({$urandom, $urandom});
            {it.norm_x, it.norm_y, it.norm_z} = 48'({$urandom, $urandom});
            return it;
        end
        if ($urandom_range(0, 3) != 0) it.material_coeffs[15:0] = 16'($urandom_range(0, 1024));
        if ($urandom_range(0, 1) != 0) it.surface_color &= {3{16'h1FFF}};
        if ($urandom_range(0, 1) != 0) it.material_coeffs[63:16] &= {3{16'h1FFF}};
        off = $urandom_range(0, 1 << 22) - (1 << 21);
        it.pos_x = light_pos[0] - 24'(off);
        off = $urandom_range(0, 1 << 22) - (1 << 21);
        it.pos_y = light_pos[1] - 24'(off);
        off = $urandom_range(0, 1 << 22) - (1 << 21);
        it.pos_z = light_pos[2] - 24'(off);
        l[0] = real'(light_pos[0] - it.pos_x);
        l[1] = real'(light_pos[1] - it.pos_y);
        l[2] = real'(light_pos[2] - it.pos_z);
        mag = $sqrt(l[0] * l[0] + l[1] * l[1] + l[2] * l[2]) + 1.0e-9;
        for (int c = 0; c < 3; c++) l[c] = l[c] / mag;
        for (int c = 0; c < 3; c++) n[c] = rand_unit();
        mag = $sqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
        if (mag < 0.01) begin
            n[0] = 0.0;
            n[1] = 0.0;
            n[2] = 1.0;
            mag = 1.0;
        end
        for (int c = 0; c < 3; c++) n[c] = n[c] / mag;
        dot = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
        if (dot < 0.0 && $urandom_range(0, 99) < 80) begin
            for (int c = 0; c < 3; c++) n[c] = -n[c];
            dot = -dot;
        end
        for (int c = 0; c < 3; c++) begin
            if ($urandom_range(0, 1) != 0) ev[c] = 2.0 * dot * n[c] - l[c] + 0.1 * rand_unit();
            else ev[c] = rand_unit();
        end
        mag = $sqrt(ev[0] * ev[0] + ev[1] * ev[1] + ev[2] * ev[2]) + 1.0e-9;
        it.eye_x = to_q14(ev[0] / mag * 0.999);
        it.eye_y = to_q14(ev[1] / mag * 0.999);
        it.eye_z = to_q14(ev[2] / mag * 0.999);
        it.norm_x = to_q14(n[0] * 0.999);
        it.norm_y = to_q14(n[1] * 0.999);
        it.norm_z = to_q14(n[2] * 0.999);
        return it;
    endfunction

    task automatic test_reset_values();
        ppls_pkg::t_in it;
        it = plain_point();
        send_point(it);
        it.pos_z = 24'sd65536;
        send_point(it);
        it.norm_z = -16'sd16384;
        send_point(it);
    endtask

    task automatic test_directed_cases();
        ppls_pkg::t_in it;
        set_light(24'd0, 24'd0, 24'd65536, 24'hFF1000, 24'h001000, 24'h001000);
        write_reg(CFG_IDX_SPARE_LO, 24'h123456);
        write_reg(CFG_IDX_SPARE_HI, 24'hFFFFFF);
        it = plain_point();
        send_point(it);
        it.shadowed = 1'b1;
        send_point(it);
        it = plain_point();
        it.norm_z = -16'sd16384;
        send_point(it);
        it = plain_point();
        it.eye_z = -16'sd16384;
        send_point(it);
        it = plain_point();
        it.material_coeffs[15:0] = 16'd0;
        send_point(it);
        it.material_coeffs[15:0] = 16'hFFFF;
        send_point(it);
        it = plain_point();
        it.pos_z = 24'sd65536;
        send_point(it);
        it = plain_point();
        it.surface_color = '1;
        it.material_coeffs = '1;
        send_point(it);
        it = plain_point();
        it.norm_z = 16'sh7FFF;
        it.eye_z = 16'sh7FFF;
        it.material_coeffs[15:0] = 16'h0800;
        send_point(it);
        it.norm_x = -16'sh8000;
        it.eye_y = -16'sh8000;
        send_point(it);
        it = plain_point();
        it.eye_z = 16'sd300;
        it.material_coeffs[15:0] = 16'hFFF0;
        send_point(it);
        it = plain_point();
        it.surface_color = '0;
        it.material_coeffs = '0;
        send_point(it);
        set_light(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFF);
        it = plain_point();
        it.pos_x = -24'sh800000;
        it.pos_y = -24'sh800000;
        it.pos_z = -24'sh800000;
        it.norm_x = 16'sd9459;
        it.norm_y = 16'sd9459;
        it.norm_z = 16'sd9459;
        it.eye_x = 16'sd9459;
        it.eye_y = 16'sd9459;
        it.eye_z = 16'sd9459;
        send_point(it);
        it.surface_color = '1;
        send_point(it);
        set_light(-24'sh800000, -24'sh800000, -24'sh800000, 24'd0, 24'd0, 24'd0);
        it.pos_x = 24'sh7FFFFF;
        it.pos_y = 24'sh7FFFFF;
        it.pos_z = 24'sh7FFFFF;
        it.norm_x = -16'sd9459;
        it.norm_y = -16'sd9459;
        it.norm_z = -16'sd9459;
        it.eye_x = -16'sd9459;
        it.eye_y = -16'sd9459;
        it.eye_z = -16'sd9459;
        send_point(it);
        drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        for (int s = 0; s < 2; s++) begin
            set_light(24'($urandom_range(0, 1 << 24)), 24'($urandom_range(0, 1 << 24)),
                      24'($urandom_range(0, 1 << 24)), 24'($urandom_range(0, 1 << 24)),
                      24'($urandom_range(0, 8192)), 24'($urandom_range(0, 65535)));
            for (int n = 0; n < count; n++) send_point(random_point());
        end
        drain();
    endtask

    initial begin
        build_pow_tables();
        light_pos[0] = '0;
        light_pos[1] = '0;
        light_pos[2] = '0;
        for (int c = 0; c < 3; c++) light_level[c] = 16'd4096;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_values();
        test_directed_cases();
        test_random_phase(0, 0, 107);
        test_random_phase(51, 0, 107);
        test_random_phase(0, 51, 107);
        test_random_phase(38, 38, 107);
        drain();
        repeat (70) @(posedge i_clk);
        if (err_count == 0 && shade_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ppls_pkg.sv
hdl/phong_point_light_shader.sv
bench/phong_point_light_shader_tb.sv
